FILE: hw/rtl/i2cmb_pkg.sv
// ----------------------------------------------------------------------------
// i2cmb_pkg
// Shared types and constants for the I2C single-byte master: the tick and
// result payloads, operation codes and the one-hot sequence steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i2cmb_pkg;

  // operation codes carried by each tick
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // reset slot length and the direction bit of the address byte
  localparam logic [15:0] SLOT_RESET  = 16'd150;
  localparam logic [15:0] SLOT_MAX    = 16'hFFFF;
  localparam logic [7:0]  ADDR_RD_BIT = 8'h01;
  localparam logic [3:0]  BITS_PER_BYTE = 4'd8;

  // one input tick
  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] device_address;
    logic [7:0] write_data;
    logic       sda_in;
  } tick_t;

  // one result per tick
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic       success;
    logic [7:0] read_data;
  } res_t;

  // sequence steps, one-hot
  typedef enum logic [25:0] {
    ST_IDLE    = 26'h0000001,
    ST_ST_A    = 26'h0000002,
    ST_ST_B    = 26'h0000004,
    ST_ST_C    = 26'h0000008,
    ST_TA_LOW  = 26'h0000010,
    ST_TA_DAT  = 26'h0000020,
    ST_TA_HIGH = 26'h0000040,
    ST_AA_LOW  = 26'h0000080,
    ST_AA_REL  = 26'h0000100,
    ST_AA_HIGH = 26'h0000200,
    ST_DA_LOW  = 26'h0000400,
    ST_DA_REL  = 26'h0000800,
    ST_DA_HIGH = 26'h0001000,
    ST_TD_LOW  = 26'h0002000,
    ST_TD_DAT  = 26'h0004000,
    ST_TD_HIGH = 26'h0008000,
    ST_RX_LOW  = 26'h0010000,
    ST_RX_HIGH = 26'h0020000,
    ST_NK_LOW  = 26'h0040000,
    ST_NK_REL  = 26'h0080000,
    ST_NK_HIGH = 26'h0100000,
    ST_NK_END  = 26'h0200000,
    ST_SP_LOW  = 26'h0400000,
    ST_SP_SDA  = 26'h0800000,
    ST_SP_SCL  = 26'h1000000,
    ST_SP_END  = 26'h2000000
  } step_t;

endpackage

`default_nettype wire

FILE: hw/rtl/i2cmb_seq.sv
// ----------------------------------------------------------------------------
// i2cmb_seq
// Bus sequencer: holds the transaction state and advances it by one tick
// per transfer, producing the pin levels and status for that tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2cmb_seq (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  tick_en,
  input  i2cmb_pkg::tick_t     tick,
  input  wire                  cfg_wr_en,
  input  wire [15:0]           cfg_wr_data,
  output i2cmb_pkg::res_t      res
);
  import i2cmb_pkg::*;

  step_t       step_r, step_nxt;
  logic [15:0] slot_ticks_r;
  logic [15:0] cnt_r, cnt_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [3:0]  bit_cnt_r, bit_cnt_nxt;
  logic        is_read_r, is_read_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [7:0]  rx_byte_r, rx_byte_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;
  logic        result_r, result_nxt;

  logic        start;
  logic [15:0] limit;
  logic [3:0]  bit_inc;
  logic        done;
  logic        ok;
  step_t       step_cur;

  assign start   = (step_r == ST_IDLE) &&
                   ((tick.operation == OP_WRITE) || (tick.operation == OP_READ));
  assign limit   = (slot_ticks_r == 16'd0) ? 16'd1 : slot_ticks_r;

  // next state for one tick
  always_comb begin
    step_cur    = step_r;
    step_nxt    = step_r;
    cnt_nxt     = cnt_r;
    shift_nxt   = shift_r;
    bit_cnt_nxt = bit_cnt_r;
    is_read_nxt = is_read_r;
    held_nxt    = held_r;
    rx_byte_nxt = rx_byte_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    result_nxt  = result_r;
    done        = 1'b0;
    ok          = 1'b0;
    bit_inc     = 4'd0;

    // load a new transaction
    if (start) begin
      is_read_nxt = (tick.operation == OP_READ);
      shift_nxt   = is_read_nxt ? (tick.device_address | ADDR_RD_BIT)
                                : tick.device_address;
      held_nxt    = tick.write_data;
      bit_cnt_nxt = 4'd0;
      cnt_nxt     = 16'd0;
      result_nxt  = 1'b0;
      step_cur    = ST_ST_A;
      step_nxt    = ST_ST_A;
    end

    if (step_cur != ST_IDLE) begin
      // pin levels for this phase
      unique case (step_cur) inside
        ST_ST_A: begin
          scl_nxt = 1'b1;
          sda_nxt = 1'b1;
        end
        ST_ST_B, ST_ST_C, ST_SP_SDA: sda_nxt = 1'b0;
        ST_TA_LOW, ST_TD_LOW, ST_AA_LOW, ST_DA_LOW,
        ST_RX_LOW, ST_NK_LOW, ST_NK_END, ST_SP_LOW: scl_nxt = 1'b0;
        ST_TA_DAT, ST_TD_DAT: sda_nxt = shift_nxt[7];
        ST_TA_HIGH, ST_TD_HIGH, ST_AA_HIGH, ST_DA_HIGH,
        ST_RX_HIGH, ST_NK_HIGH, ST_SP_SCL: scl_nxt = 1'b1;
        ST_AA_REL, ST_DA_REL, ST_NK_REL, ST_SP_END: sda_nxt = 1'b1;
        default: ;
      endcase

      // slot timer, saturating
      if (cnt_nxt != SLOT_MAX) cnt_nxt = cnt_nxt + 16'd1;

      // end of phase: sample and move on
      if (cnt_nxt >= limit) begin
        cnt_nxt = 16'd0;
        bit_inc = bit_cnt_nxt + 4'd1;
        unique case (step_cur) inside
          ST_ST_A: begin
            if (!tick.sda_in) begin
              done     = 1'b1;
              step_nxt = ST_IDLE;
            end else begin
              step_nxt = ST_ST_B;
            end
          end
          ST_ST_B: begin
            if (tick.sda_in) begin
              done     = 1'b1;
              step_nxt = ST_IDLE;
            end else begin
              step_nxt = ST_ST_C;
            end
          end
          ST_TA_HIGH, ST_TD_HIGH: begin
            shift_nxt   = {shift_nxt[6:0], 1'b0};
            bit_cnt_nxt = bit_inc;
            if (bit_inc >= BITS_PER_BYTE) begin
              bit_cnt_nxt = 4'd0;
              step_nxt    = (step_cur == ST_TA_HIGH) ? ST_AA_LOW : ST_DA_LOW;
            end else begin
              step_nxt    = (step_cur == ST_TA_HIGH) ? ST_TA_LOW : ST_TD_LOW;
            end
          end
          ST_AA_HIGH: begin
            if (is_read_nxt) begin
              bit_cnt_nxt = 4'd0;
              shift_nxt   = 8'd0;
              step_nxt    = ST_RX_LOW;
            end else if (tick.sda_in) begin
              // address NACK: stop and fail
              result_nxt  = 1'b0;
              step_nxt    = ST_SP_LOW;
            end else begin
              shift_nxt   = held_nxt;
              bit_cnt_nxt = 4'd0;
              step_nxt    = ST_TD_LOW;
            end
          end
          ST_DA_HIGH, ST_NK_END: begin
            result_nxt = 1'b1;
            step_nxt   = ST_SP_LOW;
          end
          ST_RX_HIGH: begin
            shift_nxt   = {shift_nxt[6:0], tick.sda_in};
            bit_cnt_nxt = bit_inc;
            if (bit_inc >= BITS_PER_BYTE) begin
              bit_cnt_nxt = 4'd0;
              rx_byte_nxt = shift_nxt;
              step_nxt    = ST_NK_LOW;
            end else begin
              step_nxt    = ST_RX_LOW;
            end
          end
          ST_SP_END: begin
            done     = 1'b1;
            ok       = result_nxt;
            step_nxt = ST_IDLE;
          end
          ST_ST_C:    step_nxt = ST_TA_LOW;
          ST_TA_LOW:  step_nxt = ST_TA_DAT;
          ST_TA_DAT:  step_nxt = ST_TA_HIGH;
          ST_AA_LOW:  step_nxt = ST_AA_REL;
          ST_AA_REL:  step_nxt = ST_AA_HIGH;
          ST_DA_LOW:  step_nxt = ST_DA_REL;
          ST_DA_REL:  step_nxt = ST_DA_HIGH;
          ST_TD_LOW:  step_nxt = ST_TD_DAT;
          ST_TD_DAT:  step_nxt = ST_TD_HIGH;
          ST_RX_LOW:  step_nxt = ST_RX_HIGH;
          ST_NK_LOW:  step_nxt = ST_NK_REL;
          ST_NK_REL:  step_nxt = ST_NK_HIGH;
          ST_NK_HIGH: step_nxt = ST_NK_END;
          ST_SP_LOW:  step_nxt = ST_SP_SDA;
          ST_SP_SDA:  step_nxt = ST_SP_SCL;
          ST_SP_SCL:  step_nxt = ST_SP_END;
          default:    step_nxt = ST_IDLE;
        endcase
      end
    end
  end

  // result of this tick
  always_comb begin
    res.scl_out   = scl_nxt;
    res.sda_out   = sda_nxt;
    res.busy_res  = (step_nxt != ST_IDLE);
    res.done_res  = done;
    res.success   = done & ok;
    res.read_data = rx_byte_nxt;
  end

  // slot length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_ticks_r <= SLOT_RESET;
    end else if (cfg_wr_en) begin
      slot_ticks_r <= cfg_wr_data;
    end
  end

  // sequencer state, advanced once per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r    <= ST_IDLE;
      cnt_r     <= 16'd0;
      shift_r   <= 8'd0;
      bit_cnt_r <= 4'd0;
      is_read_r <= 1'b0;
      held_r    <= 8'd0;
      rx_byte_r <= 8'd0;
      scl_r     <= 1'b1;
      sda_r     <= 1'b1;
      result_r  <= 1'b0;
    end else if (tick_en) begin
      step_r    <= step_nxt;
      cnt_r     <= cnt_nxt;
      shift_r   <= shift_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      is_read_r <= is_read_nxt;
      held_r    <= held_nxt;
      rx_byte_r <= rx_byte_nxt;
      scl_r     <= scl_nxt;
      sda_r     <= sda_nxt;
      result_r  <= result_nxt;
    end
  end

`ifndef SYNTHESIS
  // a finished transaction leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (tick_en && res.done_res) |=> (step_r == ST_IDLE))
    else $error("sequencer not idle after done");

  // success is only reported together with done
  a_ok_done: assert property (@(posedge clk) disable iff (!rst_n)
    res.success |-> res.done_res)
    else $error("success without done");

  // plain ticks leave an idle sequencer idle
  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (tick_en && (step_r == ST_IDLE) && !start) |=> (step_r == ST_IDLE))
    else $error("idle sequencer started without a start operation");

  // bit counter never passes one byte
  a_bit_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    bit_cnt_r < BITS_PER_BYTE)
    else $error("bit counter out of range");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/i2cmb_out_reg.sv
// ----------------------------------------------------------------------------
// i2cmb_out_reg
// Result register: holds one tick's result until the consumer takes it and
// stalls the tick input only while it is full and stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2cmb_out_reg (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              load,
  input  i2cmb_pkg::res_t  res,
  output logic             full_stall,
  output logic             out_valid,
  input  wire              out_stall,
  output i2cmb_pkg::res_t  out_data
);
  import i2cmb_pkg::*;

  logic valid_r, valid_nxt;
  res_t data_r;

  // register frees up when its result is taken
  assign full_stall = valid_r & out_stall;
  assign valid_nxt  = load | (valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload, loaded on each accepted tick
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

FILE: hw/rtl/i2c_master_byte_transfer_unit.sv
// ----------------------------------------------------------------------------
// i2c_master_byte_transfer_unit
// I2C master for single-byte write and read transactions, one timebase tick
// per input transfer and one result transfer per tick.
// ----------------------------------------------------------------------------
// Each input transfer is one tick of the bus timebase; every tick gives
// exactly one result with the SCL/SDA drive levels and status for that tick.
// The unit takes one tick per clock cycle unless stalled; a tick's result
// is in the output register in the next cycle. The only thing that
// holds the input back is the result register: in_stall is high while that
// register is full and out_stall is high. Each pin phase lasts cfg slot
// ticks (0 counts as 1); a write transaction, for instance, spans
// (3 + 3*8 + 3 + 3*8 + 3 + 4) phases. Write the slot length only while no
// transaction runs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_byte_transfer_unit (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_stall,
  input  i2cmb_pkg::tick_t  in_data,
  output logic              out_valid,
  input  wire               out_stall,
  output i2cmb_pkg::res_t   out_data,
  input  wire               cfg_wr_en,
  input  wire [15:0]        cfg_wr_data
);
  import i2cmb_pkg::*;

  logic tick_en;
  logic full_stall;
  res_t res;

  // a valid tick is taken whenever the result register can hold its result
  assign in_stall = full_stall;
  assign tick_en  = in_valid & ~full_stall;

  i2cmb_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick_en     (tick_en),
    .tick        (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .res         (res)
  );

  i2cmb_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (tick_en),
    .res        (res),
    .full_stall (full_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

`ifndef SYNTHESIS
  // input is held back only by a full, stalled result register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a pending result");

  // every taken tick shows up as a result in the next cycle
  a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("taken tick produced no result");

  // a done result never reports the bus as still busy
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.done_res) |-> !out_data.busy_res)
    else $error("done while busy");
`endif

endmodule

`default_nettype wire
